### src/jsfx_pkg.sv
// Shared types and character constants for the JSON string field extractor.
package jsfx_pkg;

  // Longest key that the comparison supports.
  localparam int MAX_KEY = 16;

  // Depth of the result queue between the parser and the output port.
  localparam int OUT_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2
  } reg_index_t;

  // Characters the parser looks for.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // One queued result. When split is set the entry leaves the block as two
  // results: a backslash first, then value_byte.
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       last;
    logic       found;
    logic       split;
  } result_t;

endpackage

### src/jsfx_out_fifo.sv
// Small result queue that separates the parser from the output handshake.
module jsfx_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  jsfx_pkg::result_t            push_data,
  input  logic                         pop,
  output jsfx_pkg::result_t            head,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import jsfx_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(DEPTH)) || pop)
    else $error("result queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("result queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");

endmodule

### src/json_string_field_extractor_core.sv
// JSON string field extractor: top level with input stage, parser and output port.
//
// The block reads JSON text one byte per request on the s_ stream and looks
// for the first quoted string whose raw bytes equal the configured key
// (up to 16 bytes, written through the cfg_ port while the block is idle).
// Once that key is followed by optional whitespace, a colon, optional
// whitespace and an opening quote, the string value is sent on the m_ stream
// one unescaped byte per request, and a request with tlast set and byte_valid
// clear closes it. If the text ends before the key is found, a single
// not-found request is given; if it ends inside the value, the value is
// closed as truncated. A byte of zero counts as end of text, as does s_tlast.
// Rate: one input byte is taken every clock cycle while s_tready is high.
// Each accepted byte is registered in the input stage, decoded by the parser
// and queued in a four-entry result queue, whose head is presented on the m_
// side. A byte that yields no result costs nothing downstream; an escape the
// parser does not recognise yields two output requests (the backslash and
// the byte) from one queue entry. The sustained rate is one byte per cycle
// while the queue has room. s_tready falls whenever the queued results and
// the byte held in the input stage together fill the queue, whether or not
// the output takes a request in the same cycle; it never depends on m_tready
// directly.
module json_string_field_extractor_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // end_of_text
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] value_byte
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] found
  output logic        m_tlast,   // last
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import jsfx_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1);

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SEEK,
    PH_KEY,
    PH_COLON,
    PH_PREVAL,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // Configuration registers.
  logic [63:0] key_bytes_low;
  logic [63:0] key_bytes_high;
  logic [4:0]  key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
      key_length     <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_LOW:  key_bytes_low  <= cfg_data;
        REG_KEY_HIGH: key_bytes_high <= cfg_data;
        REG_KEY_LEN:  key_length     <= cfg_data[4:0];
        default:      key_length     <= key_length;
      endcase
    end
  end

  // Input stage: the accepted byte is registered here while the parser works
  // on it.
  logic        st_valid;
  logic [7:0]  st_byte;
  logic        st_eot;
  logic [CW-1:0] q_count;

  assign s_tready = ({1'b0, q_count} + {{CW{1'b0}}, st_valid}) < (CW + 1)'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_byte <= s_tdata;
      st_eot  <= s_tlast;
    end
  end

  // Parser state.
  phase_t     phase,          phase_next;
  logic [4:0] key_position,   key_position_next;
  logic       key_mismatch,   key_mismatch_next;
  logic       escape_pending, escape_pending_next;

  logic [127:0] key_all;
  logic [7:0]   key_char;
  logic [4:0]   eff_len;
  logic         is_ws;
  logic         eot;
  logic         push;
  result_t      res;

  assign key_all  = {key_bytes_high, key_bytes_low};
  assign key_char = key_all[{key_position[3:0], 3'b000} +: 8];
  assign eff_len  = (key_length > 5'(MAX_KEY)) ? 5'(MAX_KEY) : key_length;
  assign is_ws    = (st_byte == CH_SPACE) || (st_byte == CH_TAB) ||
                    (st_byte == CH_LF) || (st_byte == CH_CR);
  assign eot      = st_eot || (st_byte == CH_NUL);

  always_comb begin
    phase_next          = phase;
    key_position_next   = key_position;
    key_mismatch_next   = key_mismatch;
    escape_pending_next = escape_pending;
    push                = 1'b0;
    res                 = '0;

    if (st_valid) begin
      if (eot) begin
        // End of text: close whatever is open and start a new document.
        if (phase == PH_VALUE) begin
          push           = 1'b1;
          res.value_byte = escape_pending ? CH_BSLASH : CH_NUL;
          res.byte_valid = escape_pending;
          res.last       = 1'b1;
          res.found      = 1'b1;
        end else if (phase != PH_DONE) begin
          push     = 1'b1;
          res.last = 1'b1;
        end
        phase_next          = PH_SEEK;
        key_position_next   = '0;
        key_mismatch_next   = 1'b0;
        escape_pending_next = 1'b0;
      end else begin
        unique case (phase)
          PH_KEY: begin
            if (!escape_pending && st_byte == CH_QUOTE) begin
              phase_next = (!key_mismatch && key_position == eff_len) ? PH_COLON : PH_SEEK;
              key_position_next = '0;
              key_mismatch_next = 1'b0;
            end else begin
              if (!key_mismatch && key_position < eff_len && st_byte == key_char) begin
                key_position_next = key_position + 5'd1;
              end else begin
                key_mismatch_next = 1'b1;
              end
              escape_pending_next = !escape_pending && st_byte == CH_BSLASH;
            end
          end
          PH_COLON: begin
            if (st_byte == CH_COLON) begin
              phase_next = PH_PREVAL;
            end else if (st_byte == CH_QUOTE) begin
              // A quote here opens a fresh candidate key.
              phase_next          = PH_KEY;
              key_position_next   = '0;
              key_mismatch_next   = 1'b0;
              escape_pending_next = 1'b0;
            end else if (!is_ws) begin
              phase_next = PH_SEEK;
            end
          end
          PH_PREVAL: begin
            if (st_byte == CH_QUOTE) begin
              phase_next          = PH_VALUE;
              escape_pending_next = 1'b0;
            end else if (!is_ws) begin
              phase_next = PH_SEEK;
            end
          end
          PH_VALUE: begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              push                = 1'b1;
              res.byte_valid      = 1'b1;
              res.found           = 1'b1;
              if (st_byte == CH_QUOTE || st_byte == CH_BSLASH || st_byte == CH_SLASH) begin
                res.value_byte = st_byte;
              end else if (st_byte == CH_LOW_N) begin
                res.value_byte = CH_LF;
              end else if (st_byte == CH_LOW_T) begin
                res.value_byte = CH_TAB;
              end else if (st_byte == CH_LOW_R) begin
                res.value_byte = CH_CR;
              end else begin
                // Unknown escape: the backslash goes out ahead of the byte.
                res.value_byte = st_byte;
                res.split      = 1'b1;
              end
            end else if (st_byte == CH_BSLASH) begin
              escape_pending_next = 1'b1;
            end else if (st_byte == CH_QUOTE) begin
              push       = 1'b1;
              res.last   = 1'b1;
              res.found  = 1'b1;
              phase_next = PH_DONE;
            end else begin
              push           = 1'b1;
              res.value_byte = st_byte;
              res.byte_valid = 1'b1;
              res.found      = 1'b1;
            end
          end
          PH_DONE: begin
            phase_next = PH_DONE;
          end
          PH_SEEK: begin
            if (st_byte == CH_QUOTE) begin
              phase_next          = PH_KEY;
              key_position_next   = '0;
              key_mismatch_next   = 1'b0;
              escape_pending_next = 1'b0;
            end
          end
          default: begin
            phase_next = PH_SEEK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEEK;
      key_position   <= '0;
      key_mismatch   <= 1'b0;
      escape_pending <= 1'b0;
    end else begin
      phase          <= phase_next;
      key_position   <= key_position_next;
      key_mismatch   <= key_mismatch_next;
      escape_pending <= escape_pending_next;
    end
  end

  // Result queue and output port.
  result_t head;
  logic    q_empty;
  logic    q_pop;
  logic    second;

  jsfx_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  // A split entry is sent as two requests; second marks that the backslash
  // has already gone.
  assign m_tvalid = !q_empty;
  assign m_tdata  = (head.split && !second) ? CH_BSLASH : head.value_byte;
  assign m_tuser  = {head.found, head.byte_valid};
  assign m_tlast  = head.last && (!head.split || second);
  assign q_pop    = m_tvalid && m_tready && (!head.split || second);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      second <= head.split && !second;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    push && !res.byte_valid |-> res.last)
    else $error("result without a value byte that does not close the document");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    st_valid && eot |=> phase == PH_SEEK && key_position == '0 && !escape_pending)
    else $error("parser state not cleared after end of text");

  a_byte_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("value byte sent without found");

  a_split_no_last: assert property (@(posedge clk) disable iff (rst)
    push && res.split |-> !res.last && res.byte_valid)
    else $error("split result carries last or lacks a byte");

endmodule

### tb/json_string_field_extractor_core_tb.sv
// Self-checking testbench for the JSON string field extractor core.
`timescale 1ns / 100ps

import jsfx_pkg::*;

// Scan phases of the predictor; the block keeps its own encoding internally.
typedef enum logic [2:0] {
  SCAN_SEEK,
  SCAN_KEY,
  SCAN_COLON,
  SCAN_PREVAL,
  SCAN_VALUE,
  SCAN_DONE
} scan_phase_t;

// One output request as the m_ side presents it.
typedef struct packed {
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       last;
  logic       found;
} value_req_t;

// Tracks the extractor state from the accepted text bytes and checks each value request.
class extract_scoreboard;
  scan_phase_t  phase;
  logic [4:0]   key_pos;
  logic         key_miss;
  logic         esc_pend;
  logic [127:0] key_all;
  logic [4:0]   key_len;
  value_req_t   expected_values[$];
  int           mismatches;
  int           results_seen;

  function new();
    key_all      = '0;
    key_len      = '0;
    mismatches   = 0;
    results_seen = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    phase    = SCAN_SEEK;
    key_pos  = '0;
    key_miss = 1'b0;
    esc_pend = 1'b0;
  endfunction

  function void open_key();
    clear_scan();
    phase = SCAN_KEY;
  endfunction

  function void set_reg(reg_index_t idx, logic [63:0] val);
    case (idx)
      REG_KEY_LOW:  key_all[63:0]   = val;
      REG_KEY_HIGH: key_all[127:64] = val;
      REG_KEY_LEN:  key_len         = val[4:0];
      default: ;
    endcase
  endfunction

  function void add_expected(logic [7:0] val, logic bv, logic lst, logic fnd);
    value_req_t req;
    req.value_byte = val;
    req.byte_valid = bv;
    req.last       = lst;
    req.found      = fnd;
    expected_values.push_back(req);
  endfunction

  function void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  // Called for every text byte accepted on the s_ side.
  function void note_request(logic [7:0] c, logic eot_in);
    logic [4:0] eff;
    logic [7:0] kc;
    logic       is_ws;
    eff   = (key_len > MAX_KEY) ? 5'(MAX_KEY) : key_len;
    kc    = key_all[8*key_pos[3:0] +: 8];
    is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    if (eot_in || c == CH_NUL) begin
      if (phase == SCAN_VALUE) begin
        if (esc_pend) add_expected(CH_BSLASH, 1'b1, 1'b1, 1'b1);
        else add_expected(8'h00, 1'b0, 1'b1, 1'b1);
      end else if (phase != SCAN_DONE) begin
        add_expected(8'h00, 1'b0, 1'b1, 1'b0);
      end
      clear_scan();
      return;
    end
    case (phase)
      SCAN_KEY: begin
        if (!esc_pend && c == CH_QUOTE) begin
          phase    = (!key_miss && key_pos == eff) ? SCAN_COLON : SCAN_SEEK;
          key_pos  = '0;
          key_miss = 1'b0;
        end else begin
          if (!key_miss && key_pos < eff && c == kc) key_pos++;
          else key_miss = 1'b1;
          esc_pend = !esc_pend && (c == CH_BSLASH);
        end
      end
      SCAN_COLON: begin
        if (c == CH_COLON) phase = SCAN_PREVAL;
        else if (c == CH_QUOTE) open_key();
        else if (!is_ws) phase = SCAN_SEEK;
      end
      SCAN_PREVAL: begin
        if (c == CH_QUOTE) begin
          phase    = SCAN_VALUE;
          esc_pend = 1'b0;
        end else if (!is_ws) begin
          phase = SCAN_SEEK;
        end
      end
      SCAN_VALUE: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_expected(c, 1'b1, 1'b0, 1'b1);
            CH_LOW_N: add_expected(CH_LF, 1'b1, 1'b0, 1'b1);
            CH_LOW_T: add_expected(CH_TAB, 1'b1, 1'b0, 1'b1);
            CH_LOW_R: add_expected(CH_CR, 1'b1, 1'b0, 1'b1);
            default: begin
              add_expected(CH_BSLASH, 1'b1, 1'b0, 1'b1);
              add_expected(c, 1'b1, 1'b0, 1'b1);
            end
          endcase
        end else if (c == CH_BSLASH) begin
          esc_pend = 1'b1;
        end else if (c == CH_QUOTE) begin
          add_expected(8'h00, 1'b0, 1'b1, 1'b1);
          phase = SCAN_DONE;
        end else begin
          add_expected(c, 1'b1, 1'b0, 1'b1);
        end
      end
      SCAN_DONE: ;
      default: begin
        if (c == CH_QUOTE) open_key();
        else phase = SCAN_SEEK;
      end
    endcase
  endfunction

  // Called for every request accepted on the m_ side.
  function void check_result(logic [7:0] val, logic bv, logic lst, logic fnd);
    value_req_t want;
    results_seen++;
    if (expected_values.size() == 0) begin
      note_failure($sformatf("unexpected request: byte %02h valid %0b last %0b found %0b",
                             val, bv, lst, fnd));
      return;
    end
    want = expected_values.pop_front();
    if (want.value_byte !== val || want.byte_valid !== bv ||
        want.last !== lst || want.found !== fnd) begin
      note_failure($sformatf({"request %0d: expected byte %02h valid %0b last %0b found %0b,",
                              " got byte %02h valid %0b last %0b found %0b"},
                             results_seen, want.value_byte, want.byte_valid, want.last,
                             want.found, val, bv, lst, fnd));
    end
  endfunction

  function void close_out();
    value_req_t want;
    while (expected_values.size() != 0) begin
      want = expected_values.pop_front();
      note_failure($sformatf("missing request: byte %02h valid %0b last %0b found %0b",
                             want.value_byte, want.byte_valid, want.last, want.found));
    end
  endfunction
endclass

module json_string_field_extractor_core_tb;

  // Escapes that the block translates to a single character.
  localparam logic [7:0] ESC_KNOWN [6] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                           CH_LOW_N, CH_LOW_T, CH_LOW_R};
  // Length of the receiver's long hold-off, in cycles.
  localparam int LONG_HOLD = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  extract_scoreboard sb;

  // Text of the current document; bit 8 is the end_of_text flag.
  logic [8:0]  text_q[$];
  logic [7:0]  key_chars[16];
  int          key_eff;
  bit          idle_on;
  bit          stall_req;
  int          bytes_sent;
  int          docs_sent;
  int          settings_used;

  json_string_field_extractor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every request leaving the block is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
    end
  end

  // Receiver. It normally accepts, drops tready in short random bursts while
  // idling is enabled, and on request holds off for a long stretch so that the
  // result queue fills and the block has to stall its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        stall_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Generous upper bound on the simulation time of a correct run.
  initial begin
    #3_000_000;
    $display("FAIL json_string_field_extractor_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Text construction
  // ---------------------------------------------------------------------------

  function void add_char(logic [7:0] c);
    text_q.push_back({1'b0, c});
  endfunction

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function void add_key_n(int n);
    for (int i = 0; i < n; i++) add_char(key_chars[i]);
  endfunction

  // Optional whitespace of every kind the block skips.
  function void add_ws();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: add_char(CH_SPACE);
        1: add_char(CH_TAB);
        2: add_char(CH_LF);
        default: add_char(CH_CR);
      endcase
    end
  endfunction

  // The end of a document comes either as tlast with an arbitrary byte or as
  // a zero byte with tlast clear.
  function void add_end();
    if ($urandom_range(0, 3) == 0) text_q.push_back({1'b0, CH_NUL});
    else text_q.push_back({1'b1, 8'($urandom)});
  endfunction

  // A byte that is neither a quote nor a backslash, spread over printable,
  // high and control codes.
  function logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: c = 8'($urandom_range(32, 126));
      7, 8:                c = 8'($urandom_range(128, 255));
      default:             c = 8'($urandom_range(1, 31));
    endcase
    if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
    return c;
  endfunction

  // Strings and fragments that look like the key but must not select a value.
  function void add_decoy();
    case ($urandom_range(0, 7))
      0: begin
        add_char(CH_QUOTE);
        repeat ($urandom_range(0, 4)) add_char(plain_char());
        add_str("\":1,");
      end
      1: begin
        add_char(CH_QUOTE);
        add_key_n((key_eff > 0) ? $urandom_range(0, key_eff - 1) : 0);
        add_str("\":2,");
      end
      2: begin
        add_char(CH_QUOTE);
        add_key_n(key_eff);
        add_char(plain_char());
        add_str("\":3,");
      end
      3: begin
        // Key matched, then something other than a colon.
        add_char(CH_QUOTE);
        add_key_n(key_eff);
        add_char(CH_QUOTE);
        add_ws();
        add_str("x,");
      end
      4: begin
        // Key matched and a quote follows: it opens a fresh string.
        add_char(CH_QUOTE);
        add_key_n(key_eff);
        add_char(CH_QUOTE);
        add_ws();
      end
      5: begin
        // Key and colon, but the value is not a string.
        add_char(CH_QUOTE);
        add_key_n(key_eff);
        add_char(CH_QUOTE);
        add_ws();
        add_char(CH_COLON);
        add_ws();
        add_str("12,");
      end
      6: add_str("\"a\\\"b\":0,");
      default: add_char(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // Value contents and its ending: closed, truncated, or truncated on a backslash.
  function void add_value();
    int tail;
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: add_char(plain_char());
        5: begin
          add_char(CH_BSLASH);
          add_char(ESC_KNOWN[$urandom_range(0, 5)]);
        end
        6: begin
          add_char(CH_BSLASH);
          add_char(8'($urandom_range(1, 255)));
        end
        default: add_char(8'($urandom_range(128, 255)));
      endcase
    end
    tail = $urandom_range(0, 9);
    if (tail < 7) begin
      add_char(CH_QUOTE);
      repeat ($urandom_range(0, 6)) add_char(8'($urandom_range(1, 255)));
    end else if (tail == 8) begin
      add_char(CH_BSLASH);
    end
  endfunction

  // Mostly well-formed documents that carry the key; a few lack it and a few are noise.
  function void build_doc();
    int kind;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 16)) add_char(8'($urandom));
    end else begin
      if ($urandom_range(0, 1)) add_char("{");
      repeat ($urandom_range(0, 2)) add_decoy();
      if (kind != 1) begin
        add_char(CH_QUOTE);
        add_key_n(key_eff);
        add_char(CH_QUOTE);
        add_ws();
        add_char(CH_COLON);
        add_ws();
        add_char(CH_QUOTE);
        add_value();
      end
    end
    add_end();
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offers one text byte and waits for the block to take the request. tvalid
  // stays high between back-to-back requests; a gap lowers it first.
  task automatic send_item(logic [8:0] item);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = item[7:0];
    s_tlast  = item[8];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(item[7:0], item[8]);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i]);
    docs_sent++;
  endtask

  // Stops offering and waits until every predicted request has arrived, then
  // lets bytes still in the pipeline that give no result drain.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_values.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Loads a key. Mode 0 uses printable characters, mode 1 all-ones bytes and
  // mode 2 arbitrary non-zero bytes; bytes beyond the length are random, and a
  // zero length clears both key registers.
  task automatic set_key(int len_val, int mode);
    logic [127:0] regs;
    logic [7:0]   ch;
    regs    = {$urandom, $urandom, $urandom, $urandom};
    key_eff = (len_val > MAX_KEY) ? MAX_KEY : len_val;
    if (len_val == 0) regs = '0;
    for (int i = 0; i < key_eff; i++) begin
      case (mode)
        0:       ch = 8'($urandom_range(33, 126));
        1:       ch = 8'hFF;
        default: ch = 8'($urandom_range(1, 255));
      endcase
      if (ch == CH_QUOTE || ch == CH_BSLASH) ch = "q";
      regs[8*i +: 8] = ch;
      key_chars[i]   = ch;
    end
    write_reg(REG_KEY_LOW, regs[63:0]);
    write_reg(REG_KEY_HIGH, regs[127:64]);
    write_reg(REG_KEY_LEN, 64'(len_val));
    settings_used++;
  endtask

  task automatic run_docs(int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_doc();
      send_text();
    end
  endtask

  // A long value sent while the receiver holds off, so the block must back
  // up into its input.
  task automatic pressure_doc();
    text_q.delete();
    add_char(CH_QUOTE);
    add_key_n(key_eff);
    add_char(CH_QUOTE);
    add_char(CH_COLON);
    add_char(CH_QUOTE);
    repeat (40) add_char(plain_char());
    add_char(CH_QUOTE);
    add_end();
    stall_req = 1'b1;
    send_text();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  int len_plan[8]  = '{0, 31, 16, 3, 17, 1, 12, 24};
  int mode_plan[8] = '{0, 2, 1, 0, 2, 0, 2, 0};

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_KEY_LOW;
    cfg_data      = '0;
    idle_on       = 1'b1;
    stall_req     = 1'b0;
    bytes_sent    = 0;
    docs_sent     = 0;
    settings_used = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with the one-character key "k". The first document
    // repeats the key after a matched key (the quote opens a new string),
    // then carries every translated escape and an unknown one, and ends
    // truncated on tlast with an all-ones byte. The second document never
    // matches and ends on a zero byte.
    set_key(1, 0);
    write_reg(REG_KEY_LOW, 64'(8'h6B));
    key_chars[0] = 8'h6B;
    text_q.delete();
    add_str("\"k\" \"k\":\"");
    add_str("\\\"");
    add_str("\\\\");
    add_str("\\/");
    add_str("\\n");
    add_str("\\t");
    add_str("\\r");
    add_str("\\x");
    text_q.push_back({1'b1, 8'hFF});
    send_text();
    text_q.delete();
    add_char(8'hFF);
    add_char(CH_NUL);
    send_text();
    wait_idle();

    // Random part: one key setting per phase, the block idle between them.
    // The long receiver hold-off falls in the full-length key phase, and the
    // last phase runs with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      if (p == 7) idle_on = 1'b0;
      set_key(len_plan[p], mode_plan[p]);
      if (p == 2) pressure_doc();
      run_docs(125);
      wait_idle();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_values.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    sb.close_out();

    $display("Sent %0d documents (%0d text bytes) over %0d key settings, checked %0d value requests.",
             docs_sent, bytes_sent, settings_used, sb.results_seen);
    $display("Stalls and gaps hit both streams, including one long receiver hold-off.");
    if (sb.mismatches == 0) begin
      $display("PASS json_string_field_extractor_core");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("FAIL json_string_field_extractor_core");
    end
    $finish;
  end

endmodule

### sim.f
src/jsfx_pkg.sv
src/jsfx_out_fifo.sv
src/json_string_field_extractor_core.sv
tb/json_string_field_extractor_core_tb.sv
